// ===== rtl/rcfd_pkg.sv =====
// Shared constants, types and codes of the remote-control receiver frame decoder.
`default_nettype none

package rcfd_pkg;

    // Bytes in a valid frame and bytes kept for decoding.
    localparam int FRAME_BYTES = 18;
    localparam int STORE_DEPTH = 16;

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_FRAME = CNT_W'(FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_STORE = CNT_W'(STORE_DEPTH);

    localparam int STICK_W = 11;
    localparam int CH_W = 12;
    localparam int MOUSE_W = 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_STICK_MID = 2'd0;
    localparam logic [1:0] REG_STICK_LIMIT = 2'd1;
    localparam logic [1:0] REG_STICK_DEAD = 2'd2;
    localparam logic [1:0] REG_MOUSE_LIMIT = 2'd3;

    localparam logic [STICK_W-1:0] MID_RESET = 11'd1024;
    localparam logic [STICK_W-1:0] LIMIT_RESET = 11'd660;
    localparam logic [STICK_W-1:0] DEAD_RESET = 11'd10;
    localparam logic [MOUSE_W-1:0] MLIMIT_RESET = 16'd32767;

    // Status codes of a result word.
    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_STICK = 2'd1;
    localparam logic [1:0] STATUS_MOUSE = 2'd2;

    typedef logic [7:0] t_byte;
    typedef logic [STORE_DEPTH-1:0][7:0] t_frame;

    typedef struct packed {
        logic [STICK_W-1:0] stick_mid;
        logic [STICK_W-1:0] stick_limit;
        logic [STICK_W-1:0] stick_dead;
        logic [MOUSE_W-1:0] mouse_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [CH_W-1:0] stick_right_x;
        logic signed [CH_W-1:0] stick_right_y;
        logic signed [CH_W-1:0] stick_left_x;
        logic signed [CH_W-1:0] stick_left_y;
        logic [1:0] switch_left;
        logic [1:0] switch_right;
        logic signed [MOUSE_W-1:0] mouse_x;
        logic signed [MOUSE_W-1:0] mouse_y;
        logic signed [MOUSE_W-1:0] mouse_z;
        logic [15:0] mouse_buttons;
        logic [15:0] key_bits;
        logic [1:0] status;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/rcfd_cell.sv =====
// One byte cell of the frame shift line.
`default_nettype none

module rcfd_cell (
    input  wire                 i_clk,
    input  wire                 i_shift,
    input  rcfd_pkg::t_byte     i_byte,
    output rcfd_pkg::t_byte     o_byte,
    output rcfd_pkg::t_byte     o_next
);
    import rcfd_pkg::*;

    t_byte r_byte;
    t_byte n_byte;

    always_comb begin
        n_byte = i_shift ? i_byte : r_byte;
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    assign o_next = n_byte;

endmodule

`default_nettype wire

// ===== rtl/rcfd_decode.sv =====
// Decode pipeline: frame snapshot, zero basing, magnitudes, checks and result register.
`default_nettype none

module rcfd_decode (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  rcfd_pkg::t_frame    i_frame,
    input  rcfd_pkg::t_cfg      i_cfg,
    output logic                o_full,
    output logic                o_valid,
    input  wire                 i_stall,
    output rcfd_pkg::t_result   o_result
);
    import rcfd_pkg::*;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy_o;

    // Stage 1: snapshot of the sixteen stored bytes.
    logic   r_v1;
    t_frame r1_frame;

    // Stage 2: zero-based sticks and mouse magnitudes.
    logic                      r_v2;
    logic signed [CH_W-1:0]    r2_ch [4];
    logic [MOUSE_W:0]          r2_mag [3];
    logic [MOUSE_W-1:0]        r2_mouse [3];
    logic [15:0]               r2_btn;
    logic [15:0]               r2_key;
    logic [3:0]                r2_sw;

    // Stage 3: stick magnitudes.
    logic                      r_v3;
    logic signed [CH_W-1:0]    r3_ch [4];
    logic [STICK_W-1:0]        r3_abs [4];
    logic [MOUSE_W:0]          r3_mag [3];
    logic [MOUSE_W-1:0]        r3_mouse [3];
    logic [15:0]               r3_btn;
    logic [15:0]               r3_key;
    logic [3:0]                r3_sw;

    logic      r_vo;
    t_result   r_res;
    t_result   n_res;
    logic [15:0] r_last_key;
    logic [15:0] n_last_key;

    logic [STICK_W-1:0]     w_raw [4];
    logic signed [CH_W-1:0] w_ch [4];
    logic [MOUSE_W-1:0]     w_mouse [3];
    logic [MOUSE_W:0]       w_mag [3];
    logic [STICK_W-1:0]     w_abs [4];
    logic signed [CH_W-1:0] w_dead [4];

    assign w_rdy_o = !r_vo || !i_stall;
    assign w_rdy3  = !r_v3 || w_rdy_o;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_full  = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
            r_last_key <= '0;
        end else begin
            if (w_rdy1) r_v1 <= i_load;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy_o) r_vo <= r_v3;
            r_last_key <= n_last_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && w_rdy1) r1_frame <= i_frame;
    end

    // The four 11-bit channels are packed little endian over bytes 0 to 5.
    always_comb begin
        w_raw[0] = {r1_frame[1][2:0], r1_frame[0]};
        w_raw[1] = {r1_frame[2][5:0], r1_frame[1][7:3]};
        w_raw[2] = {r1_frame[4][0], r1_frame[3], r1_frame[2][7:6]};
        w_raw[3] = {r1_frame[5][3:0], r1_frame[4][7:1]};
        for (int i = 0; i < 4; i++) begin
            w_ch[i] = $signed({1'b0, w_raw[i]}) - $signed({1'b0, i_cfg.stick_mid});
        end
        for (int i = 0; i < 3; i++) begin
            w_mouse[i] = {r1_frame[7 + 2 * i], r1_frame[6 + 2 * i]};
            w_mag[i] = w_mouse[i][MOUSE_W-1] ? (17'h10000 - {1'b0, w_mouse[i]})
                                             : {1'b0, w_mouse[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && w_rdy2) begin
            for (int i = 0; i < 4; i++) r2_ch[i] <= w_ch[i];
            for (int i = 0; i < 3; i++) begin
                r2_mag[i] <= w_mag[i];
                r2_mouse[i] <= w_mouse[i];
            end
            r2_btn <= {r1_frame[13], r1_frame[12]};
            r2_key <= {r1_frame[15], r1_frame[14]};
            r2_sw <= r1_frame[5][7:4];
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_abs[i] = r2_ch[i][CH_W-1] ? STICK_W'(-r2_ch[i]) : r2_ch[i][STICK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && w_rdy3) begin
            for (int i = 0; i < 4; i++) begin
                r3_ch[i] <= r2_ch[i];
                r3_abs[i] <= w_abs[i];
            end
            for (int i = 0; i < 3; i++) begin
                r3_mag[i] <= r2_mag[i];
                r3_mouse[i] <= r2_mouse[i];
            end
            r3_btn <= r2_btn;
            r3_key <= r2_key;
            r3_sw <= r2_sw;
        end
    end

    // The stick check overrides everything; a mouse error keeps the old key bitmap.
    always_comb begin
        logic stick_err;
        logic mouse_err;
        stick_err = 1'b0;
        mouse_err = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (r3_abs[i] > i_cfg.stick_limit) stick_err = 1'b1;
            w_dead[i] = (r3_abs[i] <= i_cfg.stick_dead) ? '0 : r3_ch[i];
        end
        for (int i = 0; i < 3; i++) begin
            if (r3_mag[i] >= {1'b0, i_cfg.mouse_limit}) mouse_err = 1'b1;
        end

        n_res.stick_right_x = w_dead[0];
        n_res.stick_right_y = w_dead[1];
        n_res.stick_left_x  = w_dead[2];
        n_res.stick_left_y  = w_dead[3];
        n_res.switch_left   = r3_sw[3:2];
        n_res.switch_right  = r3_sw[1:0];
        n_res.mouse_x       = r3_mouse[0];
        n_res.mouse_y       = r3_mouse[1];
        n_res.mouse_z       = r3_mouse[2];
        n_res.mouse_buttons = r3_btn;
        n_res.key_bits      = r3_key;
        n_res.status        = STATUS_OK;
        n_last_key          = r_last_key;

        if (stick_err) begin
            n_res = '0;
            n_res.status = STATUS_STICK;
        end else if (mouse_err) begin
            n_res.key_bits = r_last_key;
            n_res.status = STATUS_MOUSE;
        end

        if (!(r_v3 && w_rdy_o)) begin
            n_last_key = r_last_key;
        end else if (stick_err) begin
            n_last_key = '0;
        end else if (!mouse_err) begin
            n_last_key = r3_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && w_rdy_o) r_res <= n_res;
    end

    assign o_valid  = r_vo;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== rtl/rc_receiver_frame_decoder_unit.sv =====
// Top level of the remote-control receiver frame decoder.
//
// Input channel: one received byte per word (i_rx_byte) with i_idle_after set on the
// byte after which the serial line went idle. One word is taken per cycle unless
// stalled. Bytes shift into a row of sixteen byte cells while fewer than sixteen
// bytes of the frame are in; later bytes are only counted; the count saturates at 31.
// When the idle flag arrives and the frame held exactly FRAME_BYTES bytes, the cells
// are copied into the decode pipeline and a result word follows; otherwise the frame
// is dropped and no word is produced. Either way the count returns to zero.
// Results pass the snapshot, subtract, magnitude and check stages of the decoder.
// Throughput: one byte per cycle. A stalled output holds its word; the pipeline keeps
// taking bytes and stalls the input, every byte alike, only while all four decoder
// stages hold a finished frame and the output word cannot leave.
// Reset clears the byte count, the remembered key bitmap and all valid flags, and loads
// the configuration registers with their defaults. Configuration sits on an APB-style
// port at byte addresses 0, 4, 8 and 12. The user must write it only while the block
// is idle; the block itself does not enforce this.
`default_nettype none

module rc_receiver_frame_decoder_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_rx_byte,
    input  wire         i_idle_after,

    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic signed [11:0] o_stick_right_x,
    output logic signed [11:0] o_stick_right_y,
    output logic signed [11:0] o_stick_left_x,
    output logic signed [11:0] o_stick_left_y,
    output logic [1:0]  o_switch_left,
    output logic [1:0]  o_switch_right,
    output logic signed [15:0] o_mouse_x,
    output logic signed [15:0] o_mouse_y,
    output logic signed [15:0] o_mouse_z,
    output logic [15:0] o_mouse_buttons,
    output logic [15:0] o_key_bits,
    output logic [1:0]  o_status,

    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rcfd_pkg::*;

    logic [STICK_W-1:0] r_mid, r_limit, r_dead;
    logic [MOUSE_W-1:0] r_mlimit;
    t_cfg               w_cfg;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   w_count_inc;
    logic               w_accept;
    logic               w_shift;
    logic               w_load;
    logic               w_full;

    t_byte              w_cell_in   [STORE_DEPTH];
    t_byte              w_cell_out  [STORE_DEPTH];
    t_byte              w_cell_next [STORE_DEPTH];
    t_frame             w_frame;
    t_result            w_res;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid    <= MID_RESET;
            r_limit  <= LIMIT_RESET;
            r_dead   <= DEAD_RESET;
            r_mlimit <= MLIMIT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_STICK_MID:   r_mid    <= pwdata[STICK_W-1:0];
                REG_STICK_LIMIT: r_limit  <= pwdata[STICK_W-1:0];
                REG_STICK_DEAD:  r_dead   <= pwdata[STICK_W-1:0];
                REG_MOUSE_LIMIT: r_mlimit <= pwdata[MOUSE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STICK_MID:   prdata = 32'(r_mid);
            REG_STICK_LIMIT: prdata = 32'(r_limit);
            REG_STICK_DEAD:  prdata = 32'(r_dead);
            REG_MOUSE_LIMIT: prdata = 32'(r_mlimit);
            default:         prdata = '0;
        endcase
    end

    assign w_cfg = '{stick_mid: r_mid, stick_limit: r_limit,
                     stick_dead: r_dead, mouse_limit: r_mlimit};

    // Byte counting and frame end detection.
    assign o_in_stall  = w_full;
    assign w_accept    = i_in_valid && !w_full;
    assign w_shift     = w_accept && (r_count < CNT_STORE);
    assign w_count_inc = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;
    assign w_load      = w_accept && i_idle_after && (w_count_inc == CNT_FRAME);

    always_comb begin
        n_count = r_count;
        if (w_accept) n_count = i_idle_after ? '0 : w_count_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else          r_count <= n_count;
    end

    // Row of byte cells: the newest byte enters cell 0, so the first byte of the
    // frame ends up in the last cell.
    genvar k;
    generate
        for (k = 0; k < STORE_DEPTH; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign w_cell_in[k] = i_rx_byte;
            end else begin : g_link
                assign w_cell_in[k] = w_cell_out[k-1];
            end
            rcfd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_byte  (w_cell_in[k]),
                .o_byte  (w_cell_out[k]),
                .o_next  (w_cell_next[k])
            );
            assign w_frame[k] = w_cell_next[STORE_DEPTH-1-k];
        end
    endgenerate

    rcfd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_frame  (w_frame),
        .i_cfg    (w_cfg),
        .o_full   (w_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_res)
    );

    assign o_stick_right_x = w_res.stick_right_x;
    assign o_stick_right_y = w_res.stick_right_y;
    assign o_stick_left_x  = w_res.stick_left_x;
    assign o_stick_left_y  = w_res.stick_left_y;
    assign o_switch_left   = w_res.switch_left;
    assign o_switch_right  = w_res.switch_right;
    assign o_mouse_x       = w_res.mouse_x;
    assign o_mouse_y       = w_res.mouse_y;
    assign o_mouse_z       = w_res.mouse_z;
    assign o_mouse_buttons = w_res.mouse_buttons;
    assign o_key_bits      = w_res.key_bits;
    assign o_status        = w_res.status;

    // A rejected stick frame carries nothing but its status.
    a_stick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_STICK) |->
            (o_stick_right_x == 0 && o_stick_left_y == 0 && o_mouse_x == 0 &&
             o_mouse_buttons == 0 && o_key_bits == 0 && o_switch_left == 0))
        else $error("stick error word carries non-zero fields");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STATUS_OK || o_status == STATUS_STICK ||
                         o_status == STATUS_MOUSE))
        else $error("undefined status code");

    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_idle_after) |=> (r_count == '0))
        else $error("byte count not cleared at frame end");

    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> $past(r_count) == CNT_FRAME - 1'b1 || $past(r_count) == CNT_FRAME)
        else $error("frame decoded at wrong byte count");

endmodule

`default_nettype wire
